// ===== hw/rtl/box_occupancy_grid_rasterizer_defines.svh =====
// assertion helpers shared by the rasterizer modules
// each expects signals named clk and rst in the module that uses it
`ifndef BOX_OCCUPANCY_GRID_RASTERIZER_DEFINES_SVH
`define BOX_OCCUPANCY_GRID_RASTERIZER_DEFINES_SVH

// same-cycle implication
`define BOGR_ASSERT_NOW(name, cond, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (cond) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define BOGR_ASSERT_NEXT(name, cond, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (cond) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/bogr_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package bogr_pkg;

  localparam int GRID_CELLS_DEF = 32;
  localparam int QUEUE_DEPTH    = 2;

  // field widths
  localparam int COORD_W    = 20;
  localparam int TILE_W     = 14;
  localparam int REGION_W   = 7;
  localparam int THRESH_W   = 9;
  localparam int CELL_W     = 8;
  localparam int COUNT_W    = 13;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 20;

  // internal arithmetic widths, doubled q16.4 units
  localparam int T2_W   = TILE_W + 1;
  localparam int OFF_W  = 22;
  localparam int ORG_W  = 24;
  localparam int NUM_W  = 24;
  localparam int MAG_W  = 23;
  localparam int QUO_W  = 25;
  localparam int EDGE_W = 25;
  localparam int SQ_W   = 2 * TILE_W;
  localparam int AREA_W = 2 * T2_W;
  localparam int NEED_W = AREA_W + 9;

  // register reset values
  localparam logic [TILE_W-1:0]   TILE_RESET   = TILE_W'(256);
  localparam logic [REGION_W-1:0] REGION_RESET = REGION_W'(32);
  localparam logic [THRESH_W-1:0] THRESH_RESET = THRESH_W'(128);

  typedef enum logic [1:0] {
    KIND_CLEAR = 2'd0,
    KIND_BOX   = 2'd1,
    KIND_CELL  = 2'd2,
    KIND_QUERY = 2'd3
  } kind_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TILE_SIZE = 3'd0,
    REG_CENTER_X  = 3'd1,
    REG_CENTER_Y  = 3'd2,
    REG_REGION    = 3'd3,
    REG_THRESHOLD = 3'd4
  } cfg_reg_t;

  // room geometry derived from the registers
  typedef struct packed {
    logic [TILE_W-1:0]        t_eff;
    logic [T2_W-1:0]          t2;
    logic signed [ORG_W-1:0]  sx2;
    logic signed [ORG_W-1:0]  sy2;
    logic [NEED_W-1:0]        need;
  } geom_t;

  // classified work handed from front to back
  typedef struct packed {
    kind_t                     kind;
    logic                      span_empty;
    logic signed [CELL_W-1:0]  cell_row;
    logic signed [CELL_W-1:0]  cell_col;
    logic [CELL_W-1:0]         c0;
    logic [CELL_W-1:0]         c1;
    logic [CELL_W-1:0]         r0;
    logic [CELL_W-1:0]         r1;
    logic signed [COORD_W-1:0] box_left;
    logic signed [COORD_W-1:0] box_right;
    logic signed [COORD_W-1:0] box_top;
    logic signed [COORD_W-1:0] box_bottom;
  } cmd_t;

endpackage
`default_nettype wire

// ===== hw/rtl/bogr_ifs.sv =====
`timescale 1ns / 1ps
`default_nettype none
interface bogr_item_if;
  import bogr_pkg::*;
  logic                      valid;
  logic                      ready;
  logic [1:0]                kind;
  logic signed [COORD_W-1:0] box_left;
  logic signed [COORD_W-1:0] box_right;
  logic signed [COORD_W-1:0] box_top;
  logic signed [COORD_W-1:0] box_bottom;
  logic signed [CELL_W-1:0]  cell_row;
  logic signed [CELL_W-1:0]  cell_col;
  modport source (output valid, kind, box_left, box_right, box_top, box_bottom,
                  cell_row, cell_col, input ready);
  modport sink (input valid, kind, box_left, box_right, box_top, box_bottom,
                cell_row, cell_col, output ready);
endinterface

interface bogr_result_if;
  import bogr_pkg::*;
  logic               valid;
  logic               ready;
  logic               blocked;
  logic [COUNT_W-1:0] cells_marked;
  modport source (output valid, blocked, cells_marked, input ready);
  modport sink (input valid, blocked, cells_marked, output ready);
endinterface

interface bogr_cfg_if;
  import bogr_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/bogr_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
module bogr_ram #(
  parameter int WIDTH = bogr_pkg::GRID_CELLS_DEF,
  parameter int DEPTH = bogr_pkg::GRID_CELLS_DEF,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// ===== hw/rtl/bogr_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none
module bogr_queue #(
  parameter int DEPTH = bogr_pkg::QUEUE_DEPTH
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            push_valid,
  output logic            push_ready,
  input  bogr_pkg::cmd_t  push_cmd,
  output logic            pop_valid,
  input  logic            pop_ready,
  output bogr_pkg::cmd_t  pop_cmd
);
  import bogr_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  cmd_t          slots [DEPTH];
  logic [PW-1:0] wptr;
  logic [PW-1:0] rptr;
  logic [CW-1:0] fill;
  logic          do_push;
  logic          do_pop;

  assign push_ready = (fill != CW'(DEPTH));
  assign pop_valid  = (fill != '0);
  assign pop_cmd    = slots[rptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      fill <= '0;
    end else begin
      if (do_push) begin
        wptr <= (wptr == PW'(DEPTH - 1)) ? '0 : wptr + PW'(1);
      end
      if (do_pop) begin
        rptr <= (rptr == PW'(DEPTH - 1)) ? '0 : rptr + PW'(1);
      end
      if (do_push && !do_pop) begin
        fill <= fill + CW'(1);
      end else if (do_pop && !do_push) begin
        fill <= fill - CW'(1);
      end
    end
    if (do_push) begin
      slots[wptr] <= push_cmd;
    end
  end
endmodule
`default_nettype wire

// ===== hw/rtl/bogr_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
`include "box_occupancy_grid_rasterizer_defines.svh"
module bogr_front #(
  parameter int GRID_CELLS = bogr_pkg::GRID_CELLS_DEF
) (
  input  logic           clk,
  input  logic           rst,
  bogr_item_if.sink      item,
  input  bogr_pkg::geom_t geom,
  output logic           push_valid,
  input  logic           push_ready,
  output bogr_pkg::cmd_t push_cmd
);
  import bogr_pkg::*;

  localparam int STEP_W = $clog2(MAG_W);
  localparam logic signed [QUO_W-1:0] G_MAX = QUO_W'(GRID_CELLS - 1);

  typedef enum logic [2:0] {F_IDLE, F_LOAD, F_DIV, F_STORE, F_SPAN, F_PUSH} fstate_t;

  fstate_t                  state;
  cmd_t                     cmd;
  logic [1:0]               idx;
  logic [STEP_W-1:0]        step;
  logic                     neg;
  logic [MAG_W-1:0]         dvd;
  logic [T2_W-1:0]          rem;
  logic signed [QUO_W-1:0]  quo [4];

  logic signed [NUM_W-1:0]  num;
  logic [NUM_W-1:0]         num_abs;
  logic [T2_W:0]            trial;
  logic                     ge;
  logic [T2_W-1:0]          rem_next;
  logic signed [QUO_W-1:0]  qa;
  logic signed [QUO_W-1:0]  rinc;
  logic                     want_ceil;
  logic signed [QUO_W-1:0]  q_round;
  logic signed [QUO_W-1:0]  c0c, c1c, r0c, r1c;
  logic                     span_empty;

  // numerator of the current division, doubled units
  always_comb begin
    case (idx)
      2'd0: num = NUM_W'($signed({cmd.box_left, 1'b0})) - geom.sx2;
      2'd1: num = NUM_W'($signed({cmd.box_right, 1'b0})) - geom.sx2;
      2'd2: num = geom.sy2 - NUM_W'($signed({cmd.box_top, 1'b0}));
      default: num = geom.sy2 - NUM_W'($signed({cmd.box_bottom, 1'b0}));
    endcase
  end

  assign num_abs  = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);

  // restoring divider, one quotient bit a cycle
  assign trial    = {rem, dvd[MAG_W-1]};
  assign ge       = (trial >= {1'b0, geom.t2});
  assign rem_next = ge ? T2_W'(trial - {1'b0, geom.t2}) : T2_W'(trial);

  // floor for left and bottom edges, ceiling for right and top
  assign qa        = $signed(QUO_W'(dvd));
  assign rinc      = (rem != '0) ? QUO_W'(1) : '0;
  assign want_ceil = (idx == 2'd1) || (idx == 2'd2);
  always_comb begin
    if (neg) begin
      q_round = want_ceil ? -qa : -qa - rinc;
    end else begin
      q_round = want_ceil ? qa + rinc : qa;
    end
  end

  // clip to grid
  assign c0c = (quo[0] < 0) ? '0 : quo[0];
  assign r0c = (quo[2] < 0) ? '0 : quo[2];
  assign c1c = (quo[1] > G_MAX) ? G_MAX : quo[1];
  assign r1c = (quo[3] > G_MAX) ? G_MAX : quo[3];
  assign span_empty = (quo[0] > G_MAX) || (quo[2] > G_MAX) || (quo[1] < 0) ||
                      (quo[3] < 0) || (c0c > c1c) || (r0c > r1c);

  assign item.ready = (state == F_IDLE);
  assign push_valid = (state == F_PUSH);
  assign push_cmd   = cmd;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
    end else begin
      unique case (state)
        F_IDLE: begin
          if (item.valid) begin
            cmd.kind       <= kind_t'(item.kind);
            cmd.span_empty <= 1'b0;
            cmd.cell_row   <= item.cell_row;
            cmd.cell_col   <= item.cell_col;
            cmd.c0         <= '0;
            cmd.c1         <= '0;
            cmd.r0         <= '0;
            cmd.r1         <= '0;
            cmd.box_left   <= item.box_left;
            cmd.box_right  <= item.box_right;
            cmd.box_top    <= item.box_top;
            cmd.box_bottom <= item.box_bottom;
            idx            <= 2'd0;
            state <= (kind_t'(item.kind) == KIND_BOX) ? F_LOAD : F_PUSH;
          end
        end
        F_LOAD: begin
          neg   <= num[NUM_W-1];
          dvd   <= num_abs[MAG_W-1:0];
          rem   <= '0;
          step  <= '0;
          state <= F_DIV;
        end
        F_DIV: begin
          dvd  <= {dvd[MAG_W-2:0], ge};
          rem  <= rem_next;
          step <= step + STEP_W'(1);
          if (step == STEP_W'(MAG_W - 1)) begin
            state <= F_STORE;
          end
        end
        F_STORE: begin
          quo[idx] <= q_round;
          if (idx == 2'd3) begin
            state <= F_SPAN;
          end else begin
            idx   <= idx + 2'd1;
            state <= F_LOAD;
          end
        end
        F_SPAN: begin
          cmd.span_empty <= span_empty;
          cmd.c0         <= c0c[CELL_W-1:0];
          cmd.c1         <= c1c[CELL_W-1:0];
          cmd.r0         <= r0c[CELL_W-1:0];
          cmd.r1         <= r1c[CELL_W-1:0];
          state          <= F_PUSH;
        end
        F_PUSH: begin
          if (push_ready) begin
            state <= F_IDLE;
          end
        end
        default: state <= F_IDLE;
      endcase
    end
  end

  `BOGR_ASSERT_NOW(a_span_in_grid, push_valid && push_cmd.kind == KIND_BOX && !push_cmd.span_empty, push_cmd.c0 <= push_cmd.c1 && push_cmd.r0 <= push_cmd.r1 && push_cmd.c1 < CELL_W'(GRID_CELLS), "box span outside grid")
endmodule
`default_nettype wire

// ===== hw/rtl/bogr_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
`include "box_occupancy_grid_rasterizer_defines.svh"
module bogr_back #(
  parameter int GRID_CELLS = bogr_pkg::GRID_CELLS_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  bogr_pkg::geom_t geom,
  input  logic            pop_valid,
  output logic            pop_ready,
  input  bogr_pkg::cmd_t  pop_cmd,
  bogr_result_if.source   result
);
  import bogr_pkg::*;

  localparam int RW = $clog2(GRID_CELLS);
  localparam logic signed [CELL_W-1:0] G_LIM = CELL_W'(GRID_CELLS);

  typedef enum logic [3:0] {
    B_FETCH, B_CELL_RD, B_CELL_UPD, B_BOX_SETUP, B_ROW_RD, B_ROW_LOAD,
    B_AREA, B_TEST, B_ROW_WR
  } bstate_t;

  bstate_t                   state;
  cmd_t                      cur;
  logic [RW-1:0]             row;
  logic [RW-1:0]             col;
  logic [GRID_CELLS-1:0]     row_valid;
  logic [GRID_CELLS-1:0]     rowbuf;
  logic signed [EDGE_W-1:0]  cl_start;
  logic signed [EDGE_W-1:0]  cl;
  logic signed [EDGE_W-1:0]  ct;
  logic [AREA_W-1:0]         area;
  logic [COUNT_W-1:0]        count;
  logic                      res_valid;
  logic                      res_blocked;
  logic [COUNT_W-1:0]        res_count;

  logic                      slot_free;
  logic                      res_set;
  logic                      cell_ok;
  logic                      ram_we;
  logic [GRID_CELLS-1:0]     ram_wdata;
  logic [GRID_CELLS-1:0]     ram_rdata;
  logic [GRID_CELLS-1:0]     cell_word;
  logic                      cell_bit;
  logic signed [EDGE_W-1:0]  bl2, br2, bt2, bb2, t2s, cr, cb;
  logic signed [EDGE_W-1:0]  il, ir, it, ib, dx, dy;
  logic [AREA_W-1:0]         area_next;
  logic                      hit;
  logic [EDGE_W-1:0]         c0t, r0t;

  bogr_ram #(.WIDTH(GRID_CELLS), .DEPTH(GRID_CELLS)) u_grid (
    .clk   (clk),
    .we    (ram_we),
    .waddr (row),
    .wdata (ram_wdata),
    .raddr (row),
    .rdata (ram_rdata)
  );

  assign slot_free = !res_valid || result.ready;
  assign pop_ready = (state == B_FETCH) && slot_free;
  assign cell_ok   = (pop_cmd.cell_row >= 8'sd0) && (pop_cmd.cell_row < G_LIM) &&
                     (pop_cmd.cell_col >= 8'sd0) && (pop_cmd.cell_col < G_LIM);

  // a result word is loaded this cycle
  assign res_set = (state == B_FETCH && pop_valid && slot_free &&
                    (pop_cmd.kind == KIND_CLEAR ||
                     (pop_cmd.kind == KIND_BOX && pop_cmd.span_empty) ||
                     ((pop_cmd.kind == KIND_CELL || pop_cmd.kind == KIND_QUERY) &&
                      !cell_ok))) ||
                   (state == B_CELL_UPD) ||
                   (state == B_ROW_WR && row == cur.r1[RW-1:0]);

  // rows never written since the last clear read as empty
  assign cell_word = row_valid[row] ? ram_rdata : '0;
  assign cell_bit  = cell_word[col];
  assign ram_we    = (state == B_ROW_WR) ||
                     (state == B_CELL_UPD && cur.kind == KIND_CELL && !cell_bit);
  assign ram_wdata = (state == B_ROW_WR) ? rowbuf
                                         : (cell_word | (GRID_CELLS'(1) << col));

  // cell overlap
  assign bl2 = EDGE_W'($signed({cur.box_left, 1'b0}));
  assign br2 = EDGE_W'($signed({cur.box_right, 1'b0}));
  assign bt2 = EDGE_W'($signed({cur.box_top, 1'b0}));
  assign bb2 = EDGE_W'($signed({cur.box_bottom, 1'b0}));
  assign t2s = $signed(EDGE_W'(geom.t2));
  assign cr  = cl + t2s;
  assign cb  = ct - t2s;
  assign il  = (bl2 > cl) ? bl2 : cl;
  assign ir  = (br2 < cr) ? br2 : cr;
  assign it  = (bt2 < ct) ? bt2 : ct;
  assign ib  = (bb2 > cb) ? bb2 : cb;
  assign dx  = ir - il;
  assign dy  = it - ib;
  assign area_next = (dx > 0 && dy > 0) ?
                     AREA_W'(dx[T2_W-1:0]) * AREA_W'(dy[T2_W-1:0]) : '0;
  assign hit = ({1'b0, area, 8'b0} >= geom.need);

  assign c0t = EDGE_W'(cur.c0[RW-1:0]) * EDGE_W'(geom.t_eff);
  assign r0t = EDGE_W'(cur.r0[RW-1:0]) * EDGE_W'(geom.t_eff);

  assign result.valid        = res_valid;
  assign result.blocked      = res_blocked;
  assign result.cells_marked = res_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= B_FETCH;
      res_valid <= 1'b0;
      row_valid <= '0;
    end else begin
      if (res_set) begin
        res_valid <= 1'b1;
      end else if (result.ready) begin
        res_valid <= 1'b0;
      end
      unique case (state)
        B_FETCH: begin
          if (pop_valid && slot_free) begin
            cur   <= pop_cmd;
            count <= '0;
            unique case (pop_cmd.kind)
              KIND_CLEAR: begin
                row_valid   <= '0;
                res_blocked <= 1'b0;
                res_count   <= '0;
              end
              KIND_BOX: begin
                if (pop_cmd.span_empty) begin
                  res_blocked <= 1'b0;
                  res_count   <= '0;
                end else begin
                  row   <= pop_cmd.r0[RW-1:0];
                  state <= B_BOX_SETUP;
                end
              end
              KIND_CELL, KIND_QUERY: begin
                if (cell_ok) begin
                  row   <= pop_cmd.cell_row[RW-1:0];
                  col   <= pop_cmd.cell_col[RW-1:0];
                  state <= B_CELL_RD;
                end else begin
                  res_blocked <= (pop_cmd.kind == KIND_QUERY);
                  res_count   <= '0;
                end
              end
              default: ;
            endcase
          end
        end
        B_CELL_RD: state <= B_CELL_UPD;
        B_CELL_UPD: begin
          if (cur.kind == KIND_QUERY) begin
            res_blocked <= cell_bit;
            res_count   <= '0;
          end else begin
            res_blocked <= 1'b0;
            res_count   <= cell_bit ? '0 : COUNT_W'(1);
            row_valid[row] <= 1'b1;
          end
          state <= B_FETCH;
        end
        B_BOX_SETUP: begin
          cl_start <= EDGE_W'(geom.sx2) + {c0t[EDGE_W-2:0], 1'b0} -
                      EDGE_W'(geom.t_eff);
          ct       <= EDGE_W'(geom.sy2) - {r0t[EDGE_W-2:0], 1'b0} +
                      EDGE_W'(geom.t_eff);
          state    <= B_ROW_RD;
        end
        B_ROW_RD: state <= B_ROW_LOAD;
        B_ROW_LOAD: begin
          rowbuf <= cell_word;
          cl     <= cl_start;
          col    <= cur.c0[RW-1:0];
          state  <= B_AREA;
        end
        B_AREA: begin
          area  <= area_next;
          state <= B_TEST;
        end
        B_TEST: begin
          if (hit && !rowbuf[col]) begin
            rowbuf[col] <= 1'b1;
            count       <= count + COUNT_W'(1);
          end
          if (col == cur.c1[RW-1:0]) begin
            state <= B_ROW_WR;
          end else begin
            col   <= col + RW'(1);
            cl    <= cl + t2s;
            state <= B_AREA;
          end
        end
        B_ROW_WR: begin
          row_valid[row] <= 1'b1;
          if (row == cur.r1[RW-1:0]) begin
            res_blocked <= 1'b0;
            res_count   <= count;
            state       <= B_FETCH;
          end else begin
            row   <= row + RW'(1);
            ct    <= ct - t2s;
            state <= B_ROW_RD;
          end
        end
        default: state <= B_FETCH;
      endcase
    end
  end

  `BOGR_ASSERT_NOW(a_walk_in_span, state == B_TEST, col >= cur.c0[RW-1:0] && col <= cur.c1[RW-1:0], "column walk left its span")
  `BOGR_ASSERT_NOW(a_query_no_marks, res_valid && res_blocked, res_count == '0, "blocked word carries a mark count")
  `BOGR_ASSERT_NEXT(a_clear_empties, pop_valid && pop_ready && pop_cmd.kind == KIND_CLEAR, row_valid == '0, "clear left rows valid")
endmodule
`default_nettype wire

// ===== hw/rtl/box_occupancy_grid_rasterizer.sv =====
// back after dequeue: clear and cells outside the grid answer from the fetch state, while
// mark-cell and query read the grid row first; mark-box: front runs four serial divides,
// then the back reads each covered row, tests its cells by area and writes it back
// front takes no new word until it has pushed the last; the two-deep queue lets it divide
// the next box while the back walks the current one
// reset: synchronous, registers to defaults, grid reads empty at once (row valid flags)
`timescale 1ns / 1ps
`default_nettype none
module box_occupancy_grid_rasterizer #(
  parameter int GRID_CELLS = bogr_pkg::GRID_CELLS_DEF
) (
  input  logic          clk,
  input  logic          rst,
  bogr_item_if.sink     item,
  bogr_result_if.source result,
  bogr_cfg_if.sink      cfg
);
  import bogr_pkg::*;

  // configuration registers
  logic [TILE_W-1:0]          tile_size;
  logic signed [COORD_W-1:0]  room_center_x;
  logic signed [COORD_W-1:0]  room_center_y;
  logic [REGION_W-1:0]        region_cells;
  logic [THRESH_W-1:0]        overlap_threshold;

  // derived geometry
  logic [TILE_W-1:0]          t_eff;
  logic signed [7:0]          rc_m1;
  logic signed [T2_W-1:0]     t_s;
  logic signed [OFF_W-1:0]    off;
  logic [SQ_W-1:0]            t_sq;
  logic [NEED_W-1:0]          need;
  geom_t                      geom;

  // front to queue to back
  logic                       push_valid;
  logic                       push_ready;
  cmd_t                       push_cmd;
  logic                       pop_valid;
  logic                       pop_ready;
  cmd_t                       pop_cmd;

  // register writes, never stalled; unknown indexes are dropped
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      tile_size         <= TILE_RESET;
      room_center_x     <= '0;
      room_center_y     <= '0;
      region_cells      <= REGION_RESET;
      overlap_threshold <= THRESH_RESET;
    end else if (cfg.valid) begin
      unique case (cfg_reg_t'(cfg.index))
        REG_TILE_SIZE: tile_size         <= cfg.data[TILE_W-1:0];
        REG_CENTER_X:  room_center_x     <= $signed(cfg.data[COORD_W-1:0]);
        REG_CENTER_Y:  room_center_y     <= $signed(cfg.data[COORD_W-1:0]);
        REG_REGION:    region_cells      <= cfg.data[REGION_W-1:0];
        REG_THRESHOLD: overlap_threshold <= cfg.data[THRESH_W-1:0];
        default: ;
      endcase
    end
  end

  // a zero tile is taken as one unit
  assign t_eff = (tile_size == '0) ? TILE_W'(1) : tile_size;
  assign rc_m1 = $signed({1'b0, region_cells}) - 8'sd1;
  assign t_s   = $signed({1'b0, t_eff});

  // half-span offset of the top-left cell centre, cell area and the marking bar, each
  // registered alone between flops; the user keeps config quiet while busy, unenforced
  always_ff @(posedge clk) begin
    off  <= OFF_W'(rc_m1) * OFF_W'(t_s);
    t_sq <= SQ_W'(t_eff) * SQ_W'(t_eff);
    need <= NEED_W'(overlap_threshold) * NEED_W'({t_sq, 2'b00});
  end

  // top-left cell centre, doubled units, y grows upward
  assign geom.t_eff = t_eff;
  assign geom.t2    = {t_eff, 1'b0};
  assign geom.sx2   = ORG_W'($signed({room_center_x, 1'b0})) - ORG_W'(off);
  assign geom.sy2   = ORG_W'($signed({room_center_y, 1'b0})) + ORG_W'(off);
  assign geom.need  = need;

  // front: takes words, works out box spans with the serial divider
  bogr_front #(.GRID_CELLS(GRID_CELLS)) u_front (
    .clk        (clk),
    .rst        (rst),
    .item       (item),
    .geom       (geom),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_cmd   (push_cmd)
  );

  // short queue so divider and grid walker stall independently
  bogr_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_cmd   (push_cmd),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_cmd    (pop_cmd)
  );

  // back: grid memory, row-wise read-modify-write, result register
  bogr_back #(.GRID_CELLS(GRID_CELLS)) u_back (
    .clk       (clk),
    .rst       (rst),
    .geom      (geom),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_cmd   (pop_cmd),
    .result    (result)
  );
endmodule
`default_nettype wire

// ===== test/bogr_tb_ifs.sv =====
`timescale 1ns / 1ps
// the block's own interfaces are reused; this file only groups testbench-side types
package bogr_tb_pkg;
  import bogr_pkg::*;

  typedef struct {
    kind_t            kind;
    logic signed [19:0] left;
    logic signed [19:0] right;
    logic signed [19:0] top;
    logic signed [19:0] bottom;
    logic signed [7:0]  row;
    logic signed [7:0]  col;
    bit               has_fixed;
    logic             fixed_blocked;
    logic [12:0]      fixed_count;
  } grid_word_t;

  typedef struct {
    logic        blocked;
    logic [12:0] cells_marked;
  } grid_answer_t;
endpackage

// ===== test/tb_box_occupancy_grid_rasterizer.sv =====
`timescale 1ns / 1ps
module tb_box_occupancy_grid_rasterizer;
  import bogr_pkg::*;
  import bogr_tb_pkg::*;

  localparam int N = 32;
  localparam int RANDOM_WORDS = 1030;
  localparam longint CYCLE_LIMIT = 12000000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  always #5 clk = ~clk;

  bogr_item_if   item ();
  bogr_result_if result ();
  bogr_cfg_if    cfg ();

  box_occupancy_grid_rasterizer #(.GRID_CELLS(N)) dut (
    .clk(clk), .rst(rst), .item(item.sink), .result(result.source), .cfg(cfg.sink)
  );

  // predictor state: grid copy and register shadows
  bit          grid_shadow [N][N];
  longint      tile_sh, cx_sh, cy_sh, region_sh, thresh_sh;
  grid_answer_t answers_due [$];
  int          errors;
  longint      cycles;
  bit          hold_off;      // long receiver stall request

  function automatic longint fdiv(longint a, longint d);
    longint q;
    q = a / d;
    if ((a % d) != 0 && a < 0) q = q - 1;
    return q;
  endfunction

  function automatic bit cell_inside(longint r, longint c);
    return r >= 0 && r < N && c >= 0 && c < N;
  endfunction

  function automatic int set_shadow(longint r, longint c);
    if (!cell_inside(r, c) || grid_shadow[r][c]) return 0;
    grid_shadow[r][c] = 1'b1;
    return 1;
  endfunction

  // rasterise a box in doubled units, exact overlap test
  function automatic int rasterise_box(longint l, longint r, longint t, longint b);
    longint tt, t2, off, sx2, sy2, bl, br, bt, bb, c0, c1, r0, r1, need;
    longint cl, cr, ct, cb, il, ir, it, ib, area;
    int cnt;
    tt = (tile_sh == 0) ? 1 : tile_sh;
    t2 = 2 * tt;
    off = (region_sh - 1) * tt;
    sx2 = 2 * cx_sh - off;
    sy2 = 2 * cy_sh + off;
    bl = 2 * l; br = 2 * r; bt = 2 * t; bb = 2 * b;
    c0 = fdiv(bl - sx2, t2);
    c1 = -fdiv(-(br - sx2), t2);
    r0 = -fdiv(-(sy2 - bt), t2);
    r1 = fdiv(sy2 - bb, t2);
    need = thresh_sh * 4 * tt * tt;
    cnt = 0;
    if (c0 < 0) c0 = 0;
    if (r0 < 0) r0 = 0;
    if (c1 > N - 1) c1 = N - 1;
    if (r1 > N - 1) r1 = N - 1;
    for (longint row = r0; row <= r1; row++)
      for (longint col = c0; col <= c1; col++) begin
        cl = sx2 + 2 * col * tt - tt;
        cr = cl + t2;
        ct = sy2 - 2 * row * tt + tt;
        cb = ct - t2;
        il = (bl > cl) ? bl : cl;
        ir = (br < cr) ? br : cr;
        it = (bt < ct) ? bt : ct;
        ib = (bb > cb) ? bb : cb;
        area = (ir > il && it > ib) ? (ir - il) * (it - ib) : 0;
        if (area * 256 >= need) cnt += set_shadow(row, col);
      end
    return cnt;
  endfunction

  function automatic grid_answer_t predict_answer(grid_word_t w);
    grid_answer_t a;
    a.blocked = 1'b0;
    a.cells_marked = '0;
    case (w.kind)
      KIND_CLEAR: foreach (grid_shadow[r, c]) grid_shadow[r][c] = 1'b0;
      KIND_BOX:   a.cells_marked = 13'(rasterise_box(w.left, w.right, w.top, w.bottom));
      KIND_CELL:  a.cells_marked = 13'(set_shadow(w.row, w.col));
      default:    a.blocked = cell_inside(w.row, w.col) ? grid_shadow[w.row][w.col] : 1'b1;
    endcase
    return a;
  endfunction

  task automatic report(string what, int got, int want);
    $display("mismatch %s: got %0d expected %0d", what, got, want);
    errors++;
  endtask

  // cycle guard
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // result side: random stalls plus a long hold-off on request
  int stall_left;
  always @(posedge clk) begin
    if (rst) begin
      result.ready <= 1'b0;
      stall_left <= 0;
    end else begin
      if (result.valid && result.ready) begin
        if (answers_due.size() == 0) begin
          report("unexpected result word", 1, 0);
        end else begin
          grid_answer_t e;
          e = answers_due.pop_front();
          if (result.blocked !== e.blocked) report("blocked", result.blocked, e.blocked);
          if (result.cells_marked !== e.cells_marked)
            report("cells_marked", result.cells_marked, e.cells_marked);
        end
      end
      if (hold_off) begin
        result.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left <= stall_left - 1;
        result.ready <= 1'b0;
      end else if (result.ready && result.valid) begin
        // next gap drawn per word, with stretches of none
        if (($urandom % 4) == 0) begin
          result.ready <= 1'b1;
        end else begin
          stall_left <= $urandom_range(0, 7);
          result.ready <= 1'b0;
        end
      end else begin
        result.ready <= 1'b1;
      end
    end
  end

  // valid stays up after an accept; the next gap or a drain drops it
  task automatic send_word(grid_word_t w);
    int gap;
    grid_answer_t a;
    gap = $urandom_range(0, 7);
    if (($urandom % 3) == 0) gap = 0;
    if (gap > 0) begin
      item.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item.valid <= 1'b1;
    item.kind <= w.kind;
    item.box_left <= w.left;
    item.box_right <= w.right;
    item.box_top <= w.top;
    item.box_bottom <= w.bottom;
    item.cell_row <= w.row;
    item.cell_col <= w.col;
    @(posedge clk);
    while (!item.ready) @(posedge clk);
    // accepted at this edge: predict in order of acceptance
    a = predict_answer(w);
    if (w.has_fixed) begin
      a.blocked = w.fixed_blocked;
      a.cells_marked = w.fixed_count;
    end
    answers_due = {answers_due, a};
  endtask

  task automatic wait_drained();
    item.valid <= 1'b0;
    while (answers_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(cfg_reg_t idx, logic [19:0] value);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data <= value;
    @(posedge clk);
    while (!cfg.ready) @(posedge clk);
    cfg.valid <= 1'b0;
    case (idx)
      REG_TILE_SIZE: tile_sh = value[13:0];
      REG_CENTER_X:  cx_sh = longint'($signed(value));
      REG_CENTER_Y:  cy_sh = longint'($signed(value));
      REG_REGION:    region_sh = value[6:0];
      default:       thresh_sh = value[8:0];
    endcase
    @(posedge clk);
  endtask

  function automatic grid_word_t mk(kind_t k, int l, int r, int t, int b, int row, int col,
                                    bit fx, logic fb, int fc);
    grid_word_t w;
    w.kind = k; w.left = 20'(l); w.right = 20'(r); w.top = 20'(t); w.bottom = 20'(b);
    w.row = 8'(row); w.col = 8'(col);
    w.has_fixed = fx; w.fixed_blocked = fb; w.fixed_count = 13'(fc);
    return w;
  endfunction

  // random word: boxes (the most common kind) in the room, sometimes wide or inverted
  function automatic grid_word_t random_word(bit small_boxes);
    grid_word_t w;
    int span, x, y, wd, ht, pick;
    kind_t k;
    pick = $urandom_range(0, 99);
    k = (pick < 5) ? KIND_CLEAR : (pick < 45) ? KIND_BOX : (pick < 70) ? KIND_CELL
        : KIND_QUERY;
    span = int'((tile_sh == 0 ? 1 : tile_sh) * region_sh);
    x = int'(cx_sh) + $signed($urandom_range(0, span)) - span / 2;
    y = int'(cy_sh) + $signed($urandom_range(0, span)) - span / 2;
    wd = $urandom_range(0, small_boxes ? 3 * int'(tile_sh) : span);
    ht = $urandom_range(0, small_boxes ? 3 * int'(tile_sh) : span);
    w = mk(k, x - wd / 2, x + wd / 2, y + ht / 2, y - ht / 2,
           $urandom_range(0, 39) - 4, $urandom_range(0, 39) - 4, 0, 0, 0);
    if (($urandom % 10) == 0) begin
      // raw random fields, all bits
      w.left = 20'($urandom); w.right = 20'($urandom);
      w.top = 20'($urandom); w.bottom = 20'($urandom);
      w.row = 8'($urandom); w.col = 8'($urandom);
    end
    return w;
  endfunction

  grid_word_t directed [$];

  function automatic void add_row(grid_word_t w);
    directed = {directed, w};
  endfunction

  initial begin
    int i;
    errors = 0; cycles = 0; hold_off = 0;
    item.valid = 1'b0; item.kind = '0; item.box_left = '0; item.box_right = '0;
    item.box_top = '0; item.box_bottom = '0; item.cell_row = '0; item.cell_col = '0;
    cfg.valid = 1'b0; cfg.index = '0; cfg.data = '0;
    tile_sh = 256; cx_sh = 0; cy_sh = 0; region_sh = 32; thresh_sh = 128;
    foreach (grid_shadow[r, c]) grid_shadow[r][c] = 1'b0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed table: grid empty after reset, corners, outside cells, extremes
    add_row(mk(KIND_QUERY, 0, 0, 0, 0, 0, 0, 1, 0, 0));
    add_row(mk(KIND_QUERY, 0, 0, 0, 0, -1, 0, 1, 1, 0));
    add_row(mk(KIND_QUERY, 0, 0, 0, 0, 0, 32, 1, 1, 0));
    add_row(mk(KIND_QUERY, 0, 0, 0, 0, -128, 127, 1, 1, 0));
    add_row(mk(KIND_CELL, 0, 0, 0, 0, 0, 0, 1, 0, 1));
    add_row(mk(KIND_CELL, 0, 0, 0, 0, 0, 0, 1, 0, 0));
    add_row(mk(KIND_CELL, 0, 0, 0, 0, 31, 31, 1, 0, 1));
    add_row(mk(KIND_CELL, 0, 0, 0, 0, 127, -128, 1, 0, 0));
    add_row(mk(KIND_QUERY, 0, 0, 0, 0, 31, 31, 1, 1, 0));
    add_row(mk(KIND_CLEAR, 0, 0, 0, 0, 0, 0, 1, 0, 0));
    add_row(mk(KIND_QUERY, 0, 0, 0, 0, 31, 31, 1, 0, 0));
    add_row(mk(KIND_BOX, -100, 100, 100, -100, 0, 0, 0, 0, 0));
    add_row(mk(KIND_BOX, -524288, 524287, 524287, -524288, 0, 0, 0, 0, 0));
    add_row(mk(KIND_BOX, 300, -300, 300, -300, 0, 0, 1, 0, 0)); // inverted
    add_row(mk(KIND_BOX, 500000, 524287, 524287, 500000, 0, 0, 1, 0, 0));
    add_row(mk(KIND_QUERY, 0, 0, 0, 0, 16, 16, 0, 0, 0));
    add_row(mk(KIND_CLEAR, 0, 0, 0, 0, 0, 0, 1, 0, 0));
    foreach (directed[j]) send_word(directed[j]);
    wait_drained();

    // at zero threshold an inverted box marks nothing, a full-range box its whole span, zero tile treated as one
    write_reg(REG_THRESHOLD, 20'd0);
    write_reg(REG_TILE_SIZE, 20'd0);
    write_reg(REG_REGION, 20'd1);
    send_word(mk(KIND_BOX, 40, -40, -40, 40, 0, 0, 0, 0, 0));
    send_word(mk(KIND_BOX, -524288, 524287, 524287, -524288, 0, 0, 0, 0, 0));
    wait_drained();

    // several settings, extremes included; random part spread across them
    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0: begin
          write_reg(REG_TILE_SIZE, 20'd16); write_reg(REG_REGION, 20'd64);
          write_reg(REG_THRESHOLD, 20'd256);
          write_reg(REG_CENTER_X, 20'h80000); write_reg(REG_CENTER_Y, 20'h7FFFF);
        end
        1: begin
          write_reg(REG_TILE_SIZE, 20'd8192); write_reg(REG_REGION, 20'd2);
          write_reg(REG_THRESHOLD, 20'd1);
          write_reg(REG_CENTER_X, 20'h7FFFF); write_reg(REG_CENTER_Y, 20'h80000);
        end
        2: begin
          write_reg(REG_TILE_SIZE, 20'd256); write_reg(REG_REGION, 20'd32);
          write_reg(REG_THRESHOLD, 20'd128);
          write_reg(REG_CENTER_X, 20'd0); write_reg(REG_CENTER_Y, 20'd0);
        end
        3: begin
          write_reg(REG_TILE_SIZE, 20'($urandom_range(16, 600)));
          write_reg(REG_REGION, 20'($urandom_range(1, 64)));
          write_reg(REG_THRESHOLD, 20'($urandom_range(0, 511)));
          write_reg(REG_CENTER_X, 20'($urandom)); write_reg(REG_CENTER_Y, 20'($urandom));
        end
        4: begin
          write_reg(REG_TILE_SIZE, 20'd100); write_reg(REG_REGION, 20'd127);
          write_reg(REG_THRESHOLD, 20'd64);
        end
        default: begin
          write_reg(REG_TILE_SIZE, 20'd37); write_reg(REG_REGION, 20'd20);
          write_reg(REG_THRESHOLD, 20'd200);
        end
      endcase
      for (i = 0; i < RANDOM_WORDS / 6; i++) begin
        if (phase == 2 && i == 20) begin
          // long receiver stall while words keep coming
          fork
            begin
              hold_off = 1'b1;
              repeat (600) @(posedge clk);
              hold_off = 1'b0;
            end
          join_none
        end
        if (phase == 3 && i == 50) begin
          // sender pauses until every answer is back
          item.valid <= 1'b0;
          while (answers_due.size() != 0) @(posedge clk);
        end
        send_word(random_word(i % 8 != 0));
      end
      wait_drained();
    end

    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end
endmodule

// ===== box_occupancy_grid_rasterizer.f =====
+incdir+hw/rtl
hw/rtl/bogr_pkg.sv
hw/rtl/bogr_ifs.sv
hw/rtl/bogr_ram.sv
hw/rtl/bogr_queue.sv
hw/rtl/bogr_front.sv
hw/rtl/bogr_back.sv
hw/rtl/box_occupancy_grid_rasterizer.sv
test/bogr_tb_ifs.sv
test/tb_box_occupancy_grid_rasterizer.sv
